// File: hdl/assert_macros.svh
// Assertion macros for the RTL that checks its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
	else $error(msg);

// An antecedent that implies a consequent in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

`endif

// File: hdl/g3pc_pkg.sv
// Types, widths and latencies shared by the three-point centroid block.
`default_nettype none
package g3pc_pkg;
	localparam int COORD_BITS = 12;
	localparam int PIXEL_BITS = 24;
	localparam int FRAC_BITS  = 8;
	localparam int LOG_FRAC   = 16;

	// A positive pixel value fits in the bits below the sign.
	localparam int VAL_W   = PIXEL_BITS - 1;
	localparam int EXP_W   = $clog2(VAL_W);
	localparam int LOG_W   = EXP_W + LOG_FRAC;
	localparam int DIFF_W  = LOG_W + 2;
	localparam int QUO_W   = FRAC_BITS + 2;
	localparam int OFF_W   = FRAC_BITS + 2;
	localparam int POS_W   = COORD_BITS + FRAC_BITS;
	localparam int LOG_LAT = LOG_FRAC + 1;
	localparam int DIV_LAT = QUO_W + 3;
	localparam int SIDE_LAT = LOG_LAT + 1 + DIV_LAT;

	typedef struct packed {
		logic        [COORD_BITS-1:0] peak_x;
		logic        [COORD_BITS-1:0] peak_y;
		logic signed [PIXEL_BITS-1:0] center_value;
		logic signed [PIXEL_BITS-1:0] left_value;
		logic signed [PIXEL_BITS-1:0] right_value;
		logic signed [PIXEL_BITS-1:0] up_value;
		logic signed [PIXEL_BITS-1:0] down_value;
	} item_t;

	typedef struct packed {
		logic [POS_W-1:0] center_x;
		logic [POS_W-1:0] center_y;
		logic             fit_ok;
	} result_t;
endpackage
`default_nettype wire

// File: hdl/gaussian_three_point_centroid.sv
// Top level of the three-point Gaussian sub-pixel centroid pipeline.
// Usage: an upstream detector presents a peak pixel's coordinates and the
// values of the peak and its four neighbors on the item channel. A transfer
// happens at a rising edge where item_valid is high and item_stall is low.
// The centroid leaves on the result channel under the same rule, with
// result_stall driven by the receiver.
// From the item transfer to result_valid, an item passes one normalize
// stage and sixteen squaring stages in each logarithm lane, one merge
// stage, thirteen stages of the per-axis rounded divider, and the
// output register. Throughput is one item per cycle while no result is held.
// Five logarithm lanes run side by side, one per pixel value; the merge
// stage forms the two log ratios per axis and feeds one divider per axis.
// When the receiver stalls a waiting result, the whole pipeline holds and
// item_stall rises in the same cycle; it resumes the cycle the stall drops.
// Reset clears the valid bits, so no result appears until items arrive.
// When a neighbor equals the center, any value is not positive, or a log
// sum is zero, the integer peak position is returned with fit_ok low.
`default_nettype none
module gaussian_three_point_centroid import g3pc_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output logic         item_stall,
	input  wire item_t   item,
	output logic         result_valid,
	input  wire logic    result_stall,
	output result_t      result
);
	`include "assert_macros.svh"

	// The whole pipeline advances together unless a finished result is held.
	logic en;
	assign en         = !(result_valid && result_stall);
	assign item_stall = !en;

	// Screen for the fallback cases on the incoming values.
	logic screen_ok;
	always_comb begin
		screen_ok = 1'b1;
		if (item.left_value == item.center_value || item.right_value == item.center_value ||
		    item.up_value == item.center_value || item.down_value == item.center_value) begin
			screen_ok = 1'b0;
		end
		if (item.center_value <= 0 || item.left_value <= 0 || item.right_value <= 0 ||
		    item.up_value <= 0 || item.down_value <= 0) begin
			screen_ok = 1'b0;
		end
	end

	// Side pipeline carrying the handshake bit, coordinates and screen result.
	logic                  vld_q  [SIDE_LAT];
	logic                  ok_q   [SIDE_LAT];
	logic [COORD_BITS-1:0] px_q   [SIDE_LAT];
	logic [COORD_BITS-1:0] py_q   [SIDE_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SIDE_LAT; i++) vld_q[i] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= item_valid;
			for (int i = 1; i < SIDE_LAT; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_q[0] <= screen_ok;
			px_q[0] <= item.peak_x;
			py_q[0] <= item.peak_y;
			for (int i = 1; i < SIDE_LAT; i++) begin
				ok_q[i] <= ok_q[i-1];
				px_q[i] <= px_q[i-1];
				py_q[i] <= py_q[i-1];
			end
		end
	end

	// Logarithm lanes, one per pixel value.
	logic [LOG_W-1:0] log_c, log_l, log_r, log_u, log_d;

	g3pc_log_lane u_lane_c (.clk, .en, .value(item.center_value[VAL_W-1:0]), .log_value(log_c));
	g3pc_log_lane u_lane_l (.clk, .en, .value(item.left_value[VAL_W-1:0]),   .log_value(log_l));
	g3pc_log_lane u_lane_r (.clk, .en, .value(item.right_value[VAL_W-1:0]),  .log_value(log_r));
	g3pc_log_lane u_lane_u (.clk, .en, .value(item.up_value[VAL_W-1:0]),     .log_value(log_u));
	g3pc_log_lane u_lane_d (.clk, .en, .value(item.down_value[VAL_W-1:0]),   .log_value(log_d));

	// Merge stage: A and B per axis, then their difference and sum.
	logic signed [LOG_W:0] ax, bx, ay, by;
	assign ax = $signed({1'b0, log_c}) - $signed({1'b0, log_l});
	assign bx = $signed({1'b0, log_c}) - $signed({1'b0, log_r});
	assign ay = $signed({1'b0, log_c}) - $signed({1'b0, log_u});
	assign by = $signed({1'b0, log_c}) - $signed({1'b0, log_d});

	logic signed [DIFF_W-1:0] num_x_s1, den_x_s1, num_y_s1, den_y_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			num_x_s1 <= DIFF_W'(ax) - DIFF_W'(bx);
			den_x_s1 <= DIFF_W'(ax) + DIFF_W'(bx);
			num_y_s1 <= DIFF_W'(ay) - DIFF_W'(by);
			den_y_s1 <= DIFF_W'(ay) + DIFF_W'(by);
		end
	end

	logic signed [OFF_W-1:0] off_x, off_y;
	logic                    dz_x, dz_y;

	g3pc_axis_div u_div_x (.clk, .en, .num(num_x_s1), .den(den_x_s1), .offset(off_x),
		.den_zero(dz_x));
	g3pc_axis_div u_div_y (.clk, .en, .num(num_y_s1), .den(den_y_s1), .offset(off_y),
		.den_zero(dz_y));

	// Place the offset on the integer peak and clamp to the coordinate range.
	localparam int SW = POS_W + 2;
	localparam logic signed [SW-1:0] POS_MAX = SW'((1 << POS_W) - 1);

	function automatic logic [POS_W-1:0] place(input logic [COORD_BITS-1:0] peak,
	                                           input logic signed [OFF_W-1:0] off);
		logic signed [SW-1:0] sum;
		sum = $signed(SW'({peak, {FRAC_BITS{1'b0}}})) + SW'(off);
		if (sum < 0) begin
			place = '0;
		end else if (sum > POS_MAX) begin
			place = POS_MAX[POS_W-1:0];
		end else begin
			place = sum[POS_W-1:0];
		end
	endfunction

	logic fit;
	assign fit = ok_q[SIDE_LAT-1] && !dz_x && !dz_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (en) begin
			result_valid <= vld_q[SIDE_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result.fit_ok   <= fit;
			result.center_x <= place(px_q[SIDE_LAT-1], fit ? off_x : '0);
			result.center_y <= place(py_q[SIDE_LAT-1], fit ? off_y : '0);
		end
	end

	`ASSERT_ALWAYS(a_stall_follows_output, item_stall == (result_valid && result_stall), "item_stall out of step with the held result")
	`ASSERT_IMPLY(a_fallback_integer, result_valid && !result.fit_ok, result.center_x[FRAC_BITS-1:0] == '0 && result.center_y[FRAC_BITS-1:0] == '0, "fallback result is not on the integer grid")
	`ASSERT_IMPLY(a_valid_drops_after_transfer, $fell(result_valid), $past(!result_stall), "result dropped without a transfer")
endmodule
`default_nettype wire

// File: hdl/g3pc_log_lane.sv
// Pipelined base-two logarithm lane: one squaring stage per fraction bit.
`default_nettype none
module g3pc_log_lane import g3pc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [VAL_W-1:0] value,
	output logic      [LOG_W-1:0] log_value
);
	logic [31:0]         mant_q [LOG_FRAC+1];
	logic [LOG_FRAC-1:0] frac_q [LOG_FRAC+1];
	logic [EXP_W-1:0]    exp_q  [LOG_FRAC+1];

	logic [EXP_W-1:0] lead;
	always_comb begin
		lead = '0;
		for (int i = 0; i < VAL_W; i++) begin
			if (value[i]) lead = EXP_W'(i);
		end
	end

	// Normalize so the leading one lands on bit 31.
	always_ff @(posedge clk) begin
		if (en) begin
			exp_q[0]  <= lead;
			mant_q[0] <= 32'(value) << (6'd31 - 6'(lead));
			frac_q[0] <= '0;
		end
	end

	for (genvar k = 1; k <= LOG_FRAC; k++) begin : g_sq
		logic [63:0] sq;
		assign sq = mant_q[k-1] * mant_q[k-1];
		always_ff @(posedge clk) begin
			if (en) begin
				exp_q[k]  <= exp_q[k-1];
				frac_q[k] <= {frac_q[k-1][LOG_FRAC-2:0], sq[63]};
				mant_q[k] <= sq[63] ? sq[63:32] : sq[62:31];
			end
		end
	end

	assign log_value = {exp_q[LOG_FRAC], frac_q[LOG_FRAC]};
endmodule
`default_nettype wire

// File: hdl/g3pc_axis_div.sv
// Pipelined rounded divide for one axis offset, one quotient bit per stage.
`default_nettype none
module g3pc_axis_div import g3pc_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic signed [DIFF_W-1:0] num,
	input  wire logic signed [DIFF_W-1:0] den,
	output logic signed      [OFF_W-1:0]  offset,
	output logic                          den_zero
);
	localparam int NW = DIFF_W + FRAC_BITS + 1;
	localparam int DW = DIFF_W + 1;
	localparam int CW = DW + QUO_W;

	logic [DIFF_W-1:0] abs_num, abs_den;
	assign abs_num = num[DIFF_W-1] ? DIFF_W'(-num) : DIFF_W'(num);
	assign abs_den = den[DIFF_W-1] ? DIFF_W'(-den) : DIFF_W'(den);

	logic [NW-1:0] dividend_s1;
	logic [DW-1:0] divisor_s1;
	logic          neg_s1, numz_s1, dz_s1;

	// Rounding is folded in: (n + d/2) with d = 2|den| adds |den|.
	always_ff @(posedge clk) begin
		if (en) begin
			dividend_s1 <= (NW'(abs_num) << FRAC_BITS) + NW'(abs_den);
			divisor_s1  <= DW'(abs_den) << 1;
			neg_s1      <= num[DIFF_W-1] != den[DIFF_W-1];
			numz_s1     <= num == '0;
			dz_s1       <= den == '0;
		end
	end

	logic [CW-1:0]    rem_q  [QUO_W+1];
	logic [CW-1:0]    dvs_q  [QUO_W+1];
	logic [QUO_W-1:0] quo_q  [QUO_W+1];
	logic             sat_q  [QUO_W+1];
	logic             neg_q  [QUO_W+1];
	logic             numz_q [QUO_W+1];
	logic             dz_q   [QUO_W+1];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0]  <= CW'(dividend_s1);
			dvs_q[0]  <= CW'(divisor_s1);
			quo_q[0]  <= '0;
			sat_q[0]  <= CW'(dividend_s1) >= (CW'(divisor_s1) << QUO_W);
			neg_q[0]  <= neg_s1;
			numz_q[0] <= numz_s1;
			dz_q[0]   <= dz_s1;
		end
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_bit
		logic [CW-1:0] trial;
		logic          fits;
		assign trial = dvs_q[k] << (QUO_W - 1 - k);
		assign fits  = rem_q[k] >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k+1]  <= fits ? rem_q[k] - trial : rem_q[k];
				quo_q[k+1]  <= quo_q[k] | (QUO_W'(fits) << (QUO_W - 1 - k));
				dvs_q[k+1]  <= dvs_q[k];
				sat_q[k+1]  <= sat_q[k];
				neg_q[k+1]  <= neg_q[k];
				numz_q[k+1] <= numz_q[k];
				dz_q[k+1]   <= dz_q[k];
			end
		end
	end

	localparam logic [QUO_W-1:0] LIM = QUO_W'(1) << FRAC_BITS;
	logic [QUO_W-1:0] mag;
	assign mag = (sat_q[QUO_W] || quo_q[QUO_W] > LIM) ? LIM : quo_q[QUO_W];

	always_ff @(posedge clk) begin
		if (en) begin
			if (numz_q[QUO_W]) begin
				offset <= '0;
			end else if (neg_q[QUO_W]) begin
				offset <= -$signed(OFF_W'(mag));
			end else begin
				offset <= $signed(OFF_W'(mag));
			end
			den_zero <= dz_q[QUO_W];
		end
	end
endmodule
`default_nettype wire

// File: sim/tb_gaussian_three_point_centroid.sv
// Testbench for the three-point Gaussian centroid pipeline: directed and random items, scored result by result.
`default_nettype none
module tb_gaussian_three_point_centroid;
	import g3pc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_PCT = 23;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;

	// Expected centroids, oldest first.
	result_t centroid_queue[$];
	int fail_count = 0;
	// When set, both sides run without random idling.
	bit steady_mode = 1'b0;
	// Cycles the receiver must still hold off in a forced long stall.
	int hold_cycles = 0;

	gaussian_three_point_centroid dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always #5 clk = ~clk;

	// Fixed-point log2 with LOG_FRAC fraction bits, computed by repeated squaring
	// of the normalized mantissa.
	function automatic longint log2_q16(longint unsigned v);
		int e;
		longint unsigned m;
		longint unsigned frac;
		e = 0;
		frac = 0;
		while (e < 63 && (v >> (e + 1)) != 0)
			e++;
		m = v << (31 - e);
		for (int i = 0; i < LOG_FRAC; i++) begin
			m = (m * m) >> 31;
			frac = frac << 1;
			if (m >= (64'd1 << 32)) begin
				frac = frac | 1;
				m = m >> 1;
			end
		end
		return (longint'(e) << LOG_FRAC) | longint'(frac);
	endfunction

	// Sub-pixel offset of one axis, rounded half away from zero and clipped to one pixel.
	function automatic longint axis_shift(longint a, longint b);
		longint num;
		longint den;
		longint unsigned n;
		longint unsigned d;
		longint unsigned q;
		num = a - b;
		den = a + b;
		if (num == 0)
			return 0;
		n = longint'(num < 0 ? -num : num) << FRAC_BITS;
		d = 2 * (den < 0 ? -den : den);
		q = (n + d / 2) / d;
		if (q > (64'd1 << FRAC_BITS))
			q = 64'd1 << FRAC_BITS;
		return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
	endfunction

	// Integer peak plus offset, clamped into the centroid range.
	function automatic logic [POS_W-1:0] placed(logic [COORD_BITS-1:0] peak, longint off);
		longint r;
		r = (longint'(peak) << FRAC_BITS) + off;
		if (r < 0)
			r = 0;
		if (r > (64'd1 << POS_W) - 1)
			r = (64'd1 << POS_W) - 1;
		return r[POS_W-1:0];
	endfunction

	function automatic result_t predict_centroid(item_t it);
		result_t res;
		longint c, l, r, u, d;
		longint lc, ax, bx, ay, by;
		c = it.center_value;
		l = it.left_value;
		r = it.right_value;
		u = it.up_value;
		d = it.down_value;
		res.center_x = placed(it.peak_x, 0);
		res.center_y = placed(it.peak_y, 0);
		res.fit_ok = 1'b0;
		if (l == c || r == c || u == c || d == c)
			return res;
		if (c <= 0 || l <= 0 || r <= 0 || u <= 0 || d <= 0)
			return res;
		lc = log2_q16(c);
		ax = lc - log2_q16(l);
		bx = lc - log2_q16(r);
		ay = lc - log2_q16(u);
		by = lc - log2_q16(d);
		if (ax + bx == 0 || ay + by == 0)
			return res;
		res.center_x = placed(it.peak_x, axis_shift(ax, bx));
		res.center_y = placed(it.peak_y, axis_shift(ay, by));
		res.fit_ok = 1'b1;
		return res;
	endfunction

	// Offer one item, optionally after random idle cycles, and wait for its transfer.
	// Valid stays high on return so the next item can follow in the very next cycle.
	task automatic send_item(item_t it);
		while (!steady_mode && $urandom_range(99) < IDLE_PCT) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		centroid_queue.push_back(predict_centroid(it));
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
	endtask

	task automatic send_values(int x, int y, int c, int l, int r, int u, int d);
		item_t it;
		it.peak_x = COORD_BITS'(x);
		it.peak_y = COORD_BITS'(y);
		it.center_value = PIXEL_BITS'(c);
		it.left_value = PIXEL_BITS'(l);
		it.right_value = PIXEL_BITS'(r);
		it.up_value = PIXEL_BITS'(u);
		it.down_value = PIXEL_BITS'(d);
		send_item(it);
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		@(posedge clk);
		while (centroid_queue.size() != 0)
			@(posedge clk);
	endtask

	// A random positive pixel value from a small, a medium or the full range, the full range half the time.
	function automatic int rand_pixel();
		case ($urandom_range(3))
			0: return $urandom_range(255, 1);
			1: return $urandom_range(65535, 1);
			default: return $urandom_range(8388607, 1);
		endcase
	endfunction

	// Directed corners: extremes, each fallback reason, peaks at both ends of the coordinate range.
	task automatic test_corners();
		send_values(1, 1, 1000, 500, 400, 600, 300);
		send_values(4094, 4094, 1000, 500, 400, 600, 300);
		send_values(0, 0, 1000, 1, 999, 1, 999);
		send_values(4095, 4095, 1000, 999, 1, 999, 1);
		send_values(2048, 100, 8388607, 8388606, 1, 4194304, 2);
		send_values(100, 200, 500, 500, 100, 100, 100);
		send_values(100, 200, 500, 100, 100, 100, 500);
		send_values(100, 200, 0, 100, 100, 100, 100);
		send_values(100, 200, 1000, -1, 100, 100, 100);
		send_values(100, 200, 1000, 100, 100, 100, -8388608);
		send_values(100, 200, -8388608, -8388608, -1, -5, -7);
		send_values(300, 300, 1000, 2000, 500, 100, 100);
		send_values(300, 300, 1000, 100, 100, 4000, 250);
		send_values(300, 300, 100, 90, 90, 80, 80);
		send_values(7, 9, 8388607, 1, 1, 1, 1);
		send_values(7, 9, 2, 1, 1, 1, 1);
		send_values(4095, 0, 1000, 999, 999, 999, 999);
		wait_drained();
	endtask

	// Mostly well-formed peaks, with some noise items for the fallback paths.
	task automatic test_random_peaks(int count);
		item_t it;
		for (int i = 0; i < count; i++) begin
			it.peak_x = COORD_BITS'($urandom);
			it.peak_y = COORD_BITS'($urandom);
			it.center_value = PIXEL_BITS'(rand_pixel());
			it.left_value = PIXEL_BITS'(rand_pixel());
			it.right_value = PIXEL_BITS'(rand_pixel());
			it.up_value = PIXEL_BITS'(rand_pixel());
			it.down_value = PIXEL_BITS'(rand_pixel());
			case ($urandom_range(9))
				0: it = item_t'({$urandom, $urandom, $urandom, $urandom});
				1: it.left_value = it.center_value;
				2: it.right_value = it.left_value;
				3: it.up_value = PIXEL_BITS'($urandom);
				default: ;
			endcase
			// A peak is usually the largest of its neighbors.
			if ($urandom_range(3) != 0 && it.center_value > 0)
				it.center_value = PIXEL_BITS'(24'h7FFFFF - $urandom_range(1000));
			send_item(it);
		end
	endtask

	// The receiver holds off for a long stretch while items keep coming, so the
	// pipeline fills and pushes back on the input.
	task automatic test_backpressure();
		steady_mode = 1'b1;
		hold_cycles = 200;
		test_random_peaks(80);
		steady_mode = 1'b0;
		wait_drained();
	endtask

	// Receiver stall: random or forced by hold_cycles.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= !steady_mode && ($urandom_range(99) < IDLE_PCT);
		end
	end

	// Every result transfer is checked against the oldest expected centroid.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (centroid_queue.size() == 0) begin
				$error("result with no expectation: %p", result);
				fail_count++;
			end else begin
				want = centroid_queue.pop_front();
				if (result.center_x !== want.center_x) begin
					$error("center_x expected %0d actual %0d", want.center_x, result.center_x);
					fail_count++;
				end
				if (result.center_y !== want.center_y) begin
					$error("center_y expected %0d actual %0d", want.center_y, result.center_y);
					fail_count++;
				end
				if (result.fit_ok !== want.fit_ok) begin
					$error("fit_ok expected %0d actual %0d", want.fit_ok, result.fit_ok);
					fail_count++;
				end
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corners();
		test_backpressure();
		test_random_peaks(700);
		// The sender pauses here until every result is back.
		wait_drained();
		steady_mode = 1'b1;
		test_random_peaks(300);
		steady_mode = 1'b0;
		test_random_peaks(800);
		wait_drained();
		repeat (SIDE_LAT + 20) @(posedge clk);
		if (fail_count == 0 && centroid_queue.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Guard against a hung pipeline.
	initial begin
		#2ms;
		$display("FAILED: results differ");
		$finish;
	end
endmodule
`default_nettype wire

// File: files.f
+incdir+hdl
hdl/g3pc_pkg.sv
hdl/g3pc_log_lane.sv
hdl/g3pc_axis_div.sv
hdl/gaussian_three_point_centroid.sv
sim/tb_gaussian_three_point_centroid.sv
